### rtl/core/generational_handle_allocator_assert.svh
// assertion macros for the generational handle allocator
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define GHA_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define GHA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/gha_pkg.sv
// shared constants, codes and types of the generational handle allocator
package gha_pkg;

   localparam int MAX_SLOTS = 256;
   localparam int INDEX_W   = $clog2(MAX_SLOTS);
   localparam int COUNT_W   = INDEX_W + 1;
   localparam int VERSION_W = 16;
   localparam int MASK_W    = 32;
   localparam int OPCODE_W  = 3;
   localparam int STATUS_W  = 2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_CREATE   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_DESTROY  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_IS_VALID = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SET_SIG  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_GET_SIG  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   // decoded item handed from the control front to the slot stage
   typedef struct packed {
      logic                  valid;
      logic [OPCODE_W-1:0]   opcode;
      logic [INDEX_W-1:0]    slot;
      logic [VERSION_W-1:0]  version;
      logic [MASK_W-1:0]     signature;
      logic [STATUS_W-1:0]   status;
      logic                  fresh;
   } issue_type;

endpackage

### rtl/core/generational_handle_allocator.sv
// top level of the generational handle allocator
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   request   | start / busy          | req_opcode, req_entity_index,
//             |                       | req_entity_version, req_signature_in
//   response  | rsp_strobe (1 cycle)  | rsp_status, rsp_handle_index,
//             |                       | rsp_handle_version, rsp_handle_live,
//             |                       | rsp_signature_out
//
// one item per clock cycle while busy is low, every item gives exactly one response
// the accepting edge loads the issue register and the registered read of the slot memories,
// then the result register drives the response strobe and payload
// busy is high only while reset is high, no clearing pass is needed
// the receiver cannot stall, responses are never held
module generational_handle_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gha_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [gha_pkg::INDEX_W-1:0]   req_entity_index,
   input  logic [gha_pkg::VERSION_W-1:0] req_entity_version,
   input  logic [gha_pkg::MASK_W-1:0]    req_signature_in,
   output logic                          rsp_strobe,
   output logic [gha_pkg::STATUS_W-1:0]  rsp_status,
   output logic [gha_pkg::INDEX_W-1:0]   rsp_handle_index,
   output logic [gha_pkg::VERSION_W-1:0] rsp_handle_version,
   output logic                          rsp_handle_live,
   output logic [gha_pkg::MASK_W-1:0]    rsp_signature_out
);
   import gha_pkg::*;

`include "generational_handle_allocator_assert.svh"

   logic      accept;
   issue_type issue;

   // no item taken while reset holds the counters
   assign busy   = reset;
   assign accept = start && !busy;

   // decode, slot choice, free queue and fill count all settle at the accepting edge
   gha_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .opcode         (req_opcode),
      .entity_index   (req_entity_index),
      .entity_version (req_entity_version),
      .signature_in   (req_signature_in),
      .issue          (issue)
   );

   // version and mask read-modify-write, then the response register
   gha_slots u_slots (
      .clock              (clock),
      .reset              (reset),
      .issue              (issue),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_handle_index   (rsp_handle_index),
      .rsp_handle_version (rsp_handle_version),
      .rsp_handle_live    (rsp_handle_live),
      .rsp_signature_out  (rsp_signature_out)
   );

   // every accepted item reaches the response port through the issue and result registers
   `GHA_ASSERT_NEXT(a_accept_to_rsp, clock, reset, accept, ##1 rsp_strobe, "item lost in pipeline")
   // no response without a matching accepted item
   `GHA_ASSERT_SAME(a_rsp_from_accept, clock, reset, rsp_strobe, $past(accept, 2), "response invented")
   // a live answer only comes with ok status, a zero handle index and a zero signature
   `GHA_ASSERT_SAME(a_live_clean, clock, reset, rsp_strobe && rsp_handle_live, (rsp_status == ST_OK) && (rsp_signature_out == '0) && (rsp_handle_index == '0), "live answer mixed with other payload")
   // the decoded slot for a fresh create never reports a non-ok status
   `GHA_ASSERT_SAME(a_fresh_ok, clock, reset, issue.valid && issue.fresh, (issue.opcode == OP_CREATE) && (issue.status == ST_OK), "fresh slot flagged off create")

endmodule

### rtl/core/gha_ctrl.sv
// control front: decode, counters, free index queue with prefetched head
module gha_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [gha_pkg::OPCODE_W-1:0]  opcode,
   input  logic [gha_pkg::INDEX_W-1:0]   entity_index,
   input  logic [gha_pkg::VERSION_W-1:0] entity_version,
   input  logic [gha_pkg::MASK_W-1:0]    signature_in,
   output gha_pkg::issue_type            issue
);
   import gha_pkg::*;

   logic [INDEX_W-1:0] fifo_mem [MAX_SLOTS];
   logic [INDEX_W-1:0] head_ff, head_in;
   logic [INDEX_W-1:0] tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] alloc_ff, alloc_in;
   logic [INDEX_W-1:0] head_data_ff;
   logic               fifo_we;
   logic               in_range;

   assign in_range = {1'b0, entity_index} < alloc_ff;

   always_comb begin
      issue.valid     = accept;
      issue.opcode    = opcode;
      issue.slot      = entity_index;
      issue.version   = entity_version;
      issue.signature = signature_in;
      issue.status    = ST_OK;
      issue.fresh     = 1'b0;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      alloc_in        = alloc_ff;
      fifo_we         = 1'b0;
      case (opcode)
         OP_CREATE: begin
            if (count_ff != '0) begin
               issue.slot = head_data_ff;
               if (accept) begin
                  head_in  = head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else if (alloc_ff < COUNT_W'(MAX_SLOTS)) begin
               issue.slot  = alloc_ff[INDEX_W-1:0];
               issue.fresh = 1'b1;
               if (accept) begin
                  alloc_in = alloc_ff + 1'b1;
               end
            end else begin
               issue.status = ST_FULL;
            end
         end
         OP_DESTROY: begin
            if (!in_range) begin
               issue.status = ST_RANGE;
            end else if (count_ff == COUNT_W'(MAX_SLOTS)) begin
               issue.status = ST_OVERFLOW;
            end else if (accept) begin
               fifo_we  = 1'b1;
               tail_in  = tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_IS_VALID, OP_SET_SIG, OP_GET_SIG: begin
            if (!in_range) begin
               issue.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         alloc_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         alloc_ff <= alloc_in;
      end
   end

   // queue storage, head entry kept in a register with write bypass
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[tail_ff] <= entity_index;
      end
      if (fifo_we && (tail_ff == head_in)) begin
         head_data_ff <= entity_index;
      end else begin
         head_data_ff <= fifo_mem[head_in];
      end
   end

endmodule

### rtl/core/gha_slots.sv
// slot stage: version and mask memories, read-modify-write and result register
module gha_slots (
   input  logic                          clock,
   input  logic                          reset,
   input  gha_pkg::issue_type            issue,
   output logic                          rsp_strobe,
   output logic [gha_pkg::STATUS_W-1:0]  rsp_status,
   output logic [gha_pkg::INDEX_W-1:0]   rsp_handle_index,
   output logic [gha_pkg::VERSION_W-1:0] rsp_handle_version,
   output logic                          rsp_handle_live,
   output logic [gha_pkg::MASK_W-1:0]    rsp_signature_out
);
   import gha_pkg::*;

   logic [VERSION_W-1:0] ver_mem  [MAX_SLOTS];
   logic [MASK_W-1:0]    mask_mem [MAX_SLOTS];
   issue_type            issue_ff;
   logic [VERSION_W-1:0] ver_rd_ff;
   logic [MASK_W-1:0]    mask_rd_ff;
   logic                 ver_we, mask_we;
   logic [VERSION_W-1:0] ver_wdata;
   logic [MASK_W-1:0]    mask_wdata;
   logic                 create_ok;
   logic                 strobe_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [INDEX_W-1:0]   index_ff;
   logic [VERSION_W-1:0] version_ff;
   logic                 live_ff;
   logic [MASK_W-1:0]    sig_ff;

   assign create_ok = (issue_ff.opcode == OP_CREATE) && (issue_ff.status == ST_OK);

   always_comb begin
      ver_we     = issue_ff.valid && ((create_ok && issue_ff.fresh) ||
                   ((issue_ff.opcode == OP_DESTROY) && (issue_ff.status != ST_RANGE)));
      ver_wdata  = (issue_ff.opcode == OP_DESTROY) ? ver_rd_ff + 1'b1 : '0;
      mask_we    = issue_ff.valid && ((create_ok && issue_ff.fresh) ||
                   ((issue_ff.opcode == OP_SET_SIG) && (issue_ff.status == ST_OK)));
      mask_wdata = (issue_ff.opcode == OP_SET_SIG) ? issue_ff.signature : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff.valid <= 1'b0;
      end else begin
         issue_ff.valid <= issue.valid;
      end
      issue_ff.opcode    <= issue.opcode;
      issue_ff.slot      <= issue.slot;
      issue_ff.version   <= issue.version;
      issue_ff.signature <= issue.signature;
      issue_ff.status    <= issue.status;
      issue_ff.fresh     <= issue.fresh;
   end

   // memories, with bypass of the write in flight into the read registers
   always_ff @(posedge clock) begin
      if (ver_we) begin
         ver_mem[issue_ff.slot] <= ver_wdata;
      end
      if (mask_we) begin
         mask_mem[issue_ff.slot] <= mask_wdata;
      end
      if (ver_we && (issue_ff.slot == issue.slot)) begin
         ver_rd_ff <= ver_wdata;
      end else begin
         ver_rd_ff <= ver_mem[issue.slot];
      end
      if (mask_we && (issue_ff.slot == issue.slot)) begin
         mask_rd_ff <= mask_wdata;
      end else begin
         mask_rd_ff <= mask_mem[issue.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= issue_ff.valid;
      end
      status_ff  <= issue_ff.status;
      index_ff   <= create_ok ? issue_ff.slot : '0;
      version_ff <= (create_ok && !issue_ff.fresh) ? ver_rd_ff : '0;
      live_ff    <= (issue_ff.opcode == OP_IS_VALID) && (issue_ff.status == ST_OK) &&
                    (ver_rd_ff == issue_ff.version);
      sig_ff     <= ((issue_ff.opcode == OP_GET_SIG) && (issue_ff.status == ST_OK)) ?
                    mask_rd_ff : '0;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_handle_index   = index_ff;
   assign rsp_handle_version = version_ff;
   assign rsp_handle_live    = live_ff;
   assign rsp_signature_out  = sig_ff;

endmodule
